FILE: src/cbgc_pkg.sv
// Shared widths, types and the restoring-division step for the grid cell mapper.
`timescale 1ns / 1ps
package cbgc_pkg;

  localparam int COORD_W    = 32;  // signed Q16.16 coordinate
  localparam int EDGE_W     = 31;  // unsigned Q15.16 cell edge and radius
  localparam int CNT_W      = 11;  // cell count register
  localparam int IDX_W      = 10;  // output cell index
  localparam int CFG_ADDR_W = 3;
  localparam int MAX_CELLS  = 1024;
  localparam int BOX_W      = 34;  // box bound: coordinate plus or minus radius
  localparam int DIFF_W     = 35;  // bound minus origin
  localparam int REM_W      = 34;  // dividend magnitude
  localparam int QBITS      = 11;  // saturated quotient bits
  localparam int CMP_W      = EDGE_W + QBITS;
  localparam int CELL_W     = 13;  // signed raw cell index
  localparam int DIV_STAGES = 6;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] RegOriginX = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] RegOriginY = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] RegOriginZ = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] RegEdge    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] RegCellsX  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] RegCellsY  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] RegCellsZ  = 3'd6;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             hit;
  } div_step_t;

  // One restoring-division step against the divisor shifted up by k.
  function automatic div_step_t div_step(logic [REM_W-1:0] rem, logic [EDGE_W-1:0] dvs,
                                         int unsigned k);
    logic [CMP_W-1:0] wide_r;
    logic [CMP_W-1:0] sub;
    div_step_t        res;
    wide_r  = CMP_W'(rem);
    sub     = CMP_W'(dvs) << k;
    res.hit = (wide_r >= sub);
    res.rem = res.hit ? REM_W'(wide_r - sub) : rem;
    return res;
  endfunction

endpackage

FILE: src/capsule_bounds_to_grid_cells.sv
// Top level: capsule bounding box to clamped uniform-grid cell range.
//
//   channel  | handshake                 | beat contents
//   ---------+---------------------------+---------------------------------------
//   in       | in_valid_i / in_ready_o   | end_a_{x,y,z}, end_b_{x,y,z}, radius
//   out      | out_valid_o / out_ready_i | first/last cell per axis, overlaps_grid
//   cfg      | cfg_we_i                  | cfg_addr_i selects register, cfg_data_i
//
// One beat enters per cycle when no stage is stalled by out_ready_i.
// The pipeline depth comes from the six-stage divider (one quotient bit in its first stage,
// two in each later one) that turns each box bound into a cell index, plus box, offset,
// sign-fold and index/clamp stages. Every stage has its own valid bit and advances when it
// is empty or the next stage advances, so stalls squeeze bubbles and drop nothing.
// Reset clears the valid bits and loads the grid registers with their defaults.
`timescale 1ns / 1ps
module capsule_bounds_to_grid_cells (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cbgc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [cbgc_pkg::COORD_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [cbgc_pkg::COORD_W-1:0] end_a_x_i,
  input  logic signed [cbgc_pkg::COORD_W-1:0] end_a_y_i,
  input  logic signed [cbgc_pkg::COORD_W-1:0] end_a_z_i,
  input  logic signed [cbgc_pkg::COORD_W-1:0] end_b_x_i,
  input  logic signed [cbgc_pkg::COORD_W-1:0] end_b_y_i,
  input  logic signed [cbgc_pkg::COORD_W-1:0] end_b_z_i,
  input  logic [cbgc_pkg::EDGE_W-1:0]       radius_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cbgc_pkg::IDX_W-1:0]        first_cell_x_o,
  output logic [cbgc_pkg::IDX_W-1:0]        last_cell_x_o,
  output logic [cbgc_pkg::IDX_W-1:0]        first_cell_y_o,
  output logic [cbgc_pkg::IDX_W-1:0]        last_cell_y_o,
  output logic [cbgc_pkg::IDX_W-1:0]        first_cell_z_o,
  output logic [cbgc_pkg::IDX_W-1:0]        last_cell_z_o,
  output logic                              overlaps_grid_o
);

  localparam int NSTG      = 11;
  localparam int DIV_FIRST = 4;
  localparam int DIV_LAST  = DIV_FIRST + cbgc_pkg::DIV_STAGES - 1;
  localparam int CW        = cbgc_pkg::COORD_W;
  localparam int EW        = cbgc_pkg::EDGE_W;
  localparam int NW        = cbgc_pkg::CNT_W;
  localparam int IW        = cbgc_pkg::IDX_W;

  // ---------------- grid registers ----------------
  logic signed [CW-1:0] origin_q [3];
  logic [EW-1:0]        edge_q;
  logic [NW-1:0]        cells_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        origin_q[k] <= '0;
        cells_q[k]  <= NW'(64);
      end
      edge_q <= EW'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        cbgc_pkg::RegOriginX: origin_q[0] <= cfg_data_i;
        cbgc_pkg::RegOriginY: origin_q[1] <= cfg_data_i;
        cbgc_pkg::RegOriginZ: origin_q[2] <= cfg_data_i;
        cbgc_pkg::RegEdge:    edge_q      <= cfg_data_i[EW-1:0];
        cbgc_pkg::RegCellsX:  cells_q[0]  <= cfg_data_i[NW-1:0];
        cbgc_pkg::RegCellsY:  cells_q[1]  <= cfg_data_i[NW-1:0];
        cbgc_pkg::RegCellsZ:  cells_q[2]  <= cfg_data_i[NW-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Effective grid values: a zero edge acts as one LSB, cell counts clamp to [1, MAX].
  logic [EW-1:0]   edge_eff;
  logic [NW-1:0]   cells_eff [3];
  logic [IW-1:0]   half_cells [3];

  always_comb begin
    edge_eff = (edge_q == '0) ? EW'(1) : edge_q;
    for (int k = 0; k < 3; k++) begin
      if (cells_q[k] == '0)                        cells_eff[k] = NW'(1);
      else if (cells_q[k] > NW'(cbgc_pkg::MAX_CELLS)) cells_eff[k] = NW'(cbgc_pkg::MAX_CELLS);
      else                                         cells_eff[k] = cells_q[k];
      half_cells[k] = IW'(cells_eff[k] >> 1);
    end
  end

  // ---------------- stage handshake ----------------
  logic [NSTG:1] vld_q;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = ~vld_q[NSTG] | out_ready_i;
    for (int s = NSTG - 1; s >= 1; s--) begin
      adv[s] = ~vld_q[s] | adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) vld_q[1] <= in_valid_i;
      for (int s = 2; s <= NSTG; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  assign in_ready_o  = adv[1];
  assign out_valid_o = vld_q[NSTG];

  // ---------------- stage 1: axis-aligned box ----------------
  // Bound j: axis j/2, low bound when j is even, high bound when odd.
  logic signed [CW-1:0] end_a [3];
  logic signed [CW-1:0] end_b [3];
  logic signed [cbgc_pkg::BOX_W-1:0] box_d [6];
  logic signed [cbgc_pkg::BOX_W-1:0] box_q [6];

  always_comb begin
    logic signed [CW-1:0] mn;
    logic signed [CW-1:0] mx;
    end_a[0] = end_a_x_i;
    end_a[1] = end_a_y_i;
    end_a[2] = end_a_z_i;
    end_b[0] = end_b_x_i;
    end_b[1] = end_b_y_i;
    end_b[2] = end_b_z_i;
    for (int k = 0; k < 3; k++) begin
      mn = (end_a[k] < end_b[k]) ? end_a[k] : end_b[k];
      mx = (end_a[k] < end_b[k]) ? end_b[k] : end_a[k];
      box_d[2*k]   = cbgc_pkg::BOX_W'(mn) - $signed({3'b000, radius_i});
      box_d[2*k+1] = cbgc_pkg::BOX_W'(mx) + $signed({3'b000, radius_i});
    end
  end

  // ---------------- stage 2: offset from origin ----------------
  logic signed [cbgc_pkg::DIFF_W-1:0] diff_d [6];
  logic signed [cbgc_pkg::DIFF_W-1:0] diff_q [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      diff_d[j] = cbgc_pkg::DIFF_W'(box_q[j]) - cbgc_pkg::DIFF_W'(origin_q[j/2]);
    end
  end

  // ---------------- stage 3: fold sign for floor division ----------------
  // Negative offsets divide |d| + edge - 1 so the quotient rounds toward minus infinity.
  logic [cbgc_pkg::REM_W-1:0] mag_d [6];
  logic [cbgc_pkg::REM_W-1:0] mag_q [6];
  logic [5:0]                 neg_d, neg_q;

  always_comb begin
    logic signed [cbgc_pkg::DIFF_W-1:0] fold;
    for (int j = 0; j < 6; j++) begin
      neg_d[j] = diff_q[j][cbgc_pkg::DIFF_W-1];
      fold     = $signed({4'b0000, edge_eff}) - cbgc_pkg::DIFF_W'(1) - diff_q[j];
      mag_d[j] = neg_d[j] ? cbgc_pkg::REM_W'(fold) : cbgc_pkg::REM_W'(diff_q[j]);
    end
  end

  // ---------------- stages 4..9: dividers ----------------
  logic [cbgc_pkg::QBITS-1:0] quo [6];
  logic [5:0]                 quo_neg;

  for (genvar j = 0; j < 6; j++) begin : g_div
    cbgc_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv[DIV_LAST:DIV_FIRST]),
      .rem_i  (mag_q[j]),
      .neg_i  (neg_q[j]),
      .edge_i (edge_eff),
      .quo_o  (quo[j]),
      .neg_o  (quo_neg[j])
    );
  end

  // ---------------- stage 10: signed cell index ----------------
  logic signed [cbgc_pkg::CELL_W-1:0] cell_d [6];
  logic signed [cbgc_pkg::CELL_W-1:0] cell_q [6];

  always_comb begin
    logic signed [cbgc_pkg::QBITS:0] qs;
    for (int j = 0; j < 6; j++) begin
      qs = quo_neg[j] ? -$signed({1'b0, quo[j]}) : $signed({1'b0, quo[j]});
      cell_d[j] = cbgc_pkg::CELL_W'(qs) + $signed({3'b000, half_cells[j/2]});
    end
  end

  // ---------------- stage 11: overlap test, clamp, output beat ----------------
  logic [IW-1:0] first_d [3];
  logic [IW-1:0] last_d [3];
  logic          hit_d;
  logic [IW-1:0] first_q [3];
  logic [IW-1:0] last_q [3];
  logic          hit_q;

  always_comb begin
    logic signed [cbgc_pkg::CELL_W-1:0] ncells;
    logic outside;
    outside = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ncells = $signed({2'b00, cells_eff[k]});
      if (cell_q[2*k] >= ncells || cell_q[2*k+1] < 0) outside = 1'b1;
      first_d[k] = (cell_q[2*k] < 0) ? '0 : cell_q[2*k][IW-1:0];
      last_d[k]  = (cell_q[2*k+1] >= ncells) ? IW'(cells_eff[k] - NW'(1))
                                             : cell_q[2*k+1][IW-1:0];
    end
    hit_d = ~outside;
    if (outside) begin
      for (int k = 0; k < 3; k++) begin
        first_d[k] = '0;
        last_d[k]  = '0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 6; j++) begin
      if (adv[1])  box_q[j]  <= box_d[j];
      if (adv[2])  diff_q[j] <= diff_d[j];
      if (adv[3])  mag_q[j]  <= mag_d[j];
      if (adv[10]) cell_q[j] <= cell_d[j];
    end
    if (adv[3]) neg_q <= neg_d;
    if (adv[11]) begin
      for (int k = 0; k < 3; k++) begin
        first_q[k] <= first_d[k];
        last_q[k]  <= last_d[k];
      end
      hit_q <= hit_d;
    end
  end

  assign first_cell_x_o  = first_q[0];
  assign last_cell_x_o   = last_q[0];
  assign first_cell_y_o  = first_q[1];
  assign last_cell_y_o   = last_q[1];
  assign first_cell_z_o  = first_q[2];
  assign last_cell_z_o   = last_q[2];
  assign overlaps_grid_o = hit_q;

endmodule

FILE: src/cbgc_div.sv
// Pipelined saturating divider: two quotient bits per stage after the first, saturates at all ones.
`timescale 1ns / 1ps
module cbgc_div (
  input  logic                                clk_i,
  input  logic [cbgc_pkg::DIV_STAGES-1:0]     en_i,
  input  logic [cbgc_pkg::REM_W-1:0]          rem_i,
  input  logic                                neg_i,
  input  logic [cbgc_pkg::EDGE_W-1:0]         edge_i,
  output logic [cbgc_pkg::QBITS-1:0]          quo_o,
  output logic                                neg_o
);

  localparam int NS = cbgc_pkg::DIV_STAGES;
  localparam int QB = cbgc_pkg::QBITS;

  logic [cbgc_pkg::REM_W-1:0] rem_q [NS];
  logic [cbgc_pkg::REM_W-1:0] rem_d [NS];
  logic [QB-1:0]              quo_q [NS];
  logic [QB-1:0]              quo_d [NS];
  logic [NS-1:0]              sat_q, sat_d;
  logic [NS-1:0]              neg_q, neg_d;

  always_comb begin
    cbgc_pkg::div_step_t st_a;
    cbgc_pkg::div_step_t st_b;
    // first stage: overflow check and the top quotient bit
    st_a     = cbgc_pkg::div_step(rem_i, edge_i, QB - 1);
    rem_d[0] = st_a.rem;
    quo_d[0] = '0;
    quo_d[0][QB-1] = st_a.hit;
    sat_d[0] = (cbgc_pkg::CMP_W'(rem_i) >= (cbgc_pkg::CMP_W'(edge_i) << QB));
    neg_d[0] = neg_i;
    for (int s = 1; s < NS; s++) begin
      st_a     = cbgc_pkg::div_step(rem_q[s-1], edge_i, QB - 2*s);
      st_b     = cbgc_pkg::div_step(st_a.rem, edge_i, QB - 1 - 2*s);
      rem_d[s] = st_b.rem;
      quo_d[s] = quo_q[s-1];
      quo_d[s][QB-2*s]   = st_a.hit;
      quo_d[s][QB-1-2*s] = st_b.hit;
      sat_d[s] = sat_q[s-1];
      neg_d[s] = neg_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        sat_q[s] <= sat_d[s];
        neg_q[s] <= neg_d[s];
      end
    end
  end

  assign quo_o = sat_q[NS-1] ? '1 : quo_q[NS-1];
  assign neg_o = neg_q[NS-1];

endmodule
